// ----- rtl/hcbp_pkg.sv -----
// Package with the shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  // Default longest code that the table accepts.
  localparam int MaxCodeLenDef = 32;

  // Width of the code_bits input field.
  localparam int CodeBitsW = 32;

  // Width of the code_length input field.
  localparam int CodeLenInW = 6;

  // Bits in one output byte.
  localparam int ByteBits = 8;

  // Most bits that can wait for a byte to complete.
  localparam int PendW = 7;

  // Bits needed to count the waiting bits.
  localparam int PendCntW = 3;

  // Action codes of an input beat.
  typedef enum logic [1:0] {
    ActLoad   = 2'd0,
    ActEncode = 2'd1,
    ActFlush  = 2'd2,
    ActNone   = 2'd3
  } action_e;

endpackage

// ----- rtl/hcbp_code_table.sv -----
// Code table memory: one write port and one registered read port.
module hcbp_code_table #(
  parameter int CodeW = 32,
  parameter int LenW  = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [7:0]       wr_addr_i,
  input  logic [CodeW-1:0] wr_code_i,
  input  logic [LenW-1:0]  wr_len_i,
  input  logic             rd_en_i,
  input  logic [7:0]       rd_addr_i,
  output logic [CodeW-1:0] rd_code_o,
  output logic [LenW-1:0]  rd_len_o
);

  logic [CodeW+LenW-1:0] mem [256];
  logic [CodeW+LenW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_len_i, wr_code_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_code_o = rd_q[CodeW-1:0];
  assign rd_len_o  = rd_q[CodeW+LenW-1:CodeW];

endmodule

// ----- rtl/huffman_code_bit_packer.sv -----
// Top level of the static-table Huffman encoder with an MSB-first bit packer.
//
// A load beat writes one entry of a 256-entry code table (its length is
// saturated to the smaller of MAX_CODE_LEN and 32, and the code bits above
// that length are dropped). An encode beat reads the code of its symbol and
// appends it, first code bit first, to a bit accumulator of at most seven
// waiting bits; every byte that completes leaves as one output beat with
// last low, the earliest bit in bit seven. A flush beat sends the waiting
// bits as one byte padded with zero low bits and marked last, and empties
// the accumulator; with nothing waiting it sends nothing. An empty code, a
// load and the unused action code send nothing. The first byte of an item
// is offered once stage one has read its table entry and the burst register
// has taken it. Output goes through a burst register that sends one byte a
// cycle while out_ready_i is high; it takes a new item only once the last
// byte of the one before leaves, so an item that makes n bytes (up to four
// at the default code length) holds back the items behind it until all n
// have left, and an item that makes no byte or one byte is followed at once
// when the receiver is ready. The table memory is not cleared after reset:
// an entry must be loaded before a symbol that uses it is encoded.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  symbol_i,
  input  logic [31:0] code_bits_i,
  input  logic [5:0]  code_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  // Longest code actually stored, and the widths that follow from it.
  localparam int CapLen   = (MAX_CODE_LEN < hcbp_pkg::CodeBitsW) ?
                            MAX_CODE_LEN : hcbp_pkg::CodeBitsW;
  localparam int CodeW    = CapLen;
  localparam int LenW     = $clog2(CapLen + 1);
  localparam int LenInW   = hcbp_pkg::CodeLenInW;
  localparam int AccW     = CodeW + hcbp_pkg::PendW;
  localparam int TotW     = $clog2(AccW + 1);
  localparam int MaxBytes = AccW / hcbp_pkg::ByteBits;
  localparam int CntW     = $clog2(MaxBytes + 1);

  // Input beat handshake.
  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // Load path: saturate the length and mask the code before the write.
  logic [LenW-1:0]  ld_len;
  logic [CodeW-1:0] ld_code;

  always_comb begin
    if (code_length_i > LenInW'(CapLen)) begin
      ld_len = LenW'(CapLen);
    end else begin
      ld_len = code_length_i[LenW-1:0];
    end
    for (int i = 0; i < CodeW; i++) begin
      ld_code[i] = code_bits_i[i] && (i < int'(ld_len));
    end
  end

  logic [CodeW-1:0] tab_code;
  logic [LenW-1:0]  tab_len;

  hcbp_code_table #(
    .CodeW(CodeW),
    .LenW (LenW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (in_fire && (action_i == hcbp_pkg::ActLoad)),
    .wr_addr_i(symbol_i),
    .wr_code_i(ld_code),
    .wr_len_i (ld_len),
    .rd_en_i  (in_fire && (action_i == hcbp_pkg::ActEncode)),
    .rd_addr_i(symbol_i),
    .rd_code_o(tab_code),
    .rd_len_o (tab_len)
  );

  // Stage one: the action of the item whose table entry is now read out.
  logic                s1_valid_q, s1_valid_d;
  hcbp_pkg::action_e   s1_action_q;
  logic                s1_take;

  // Accumulator of bits that do not yet fill a byte.
  logic [hcbp_pkg::PendW-1:0]    pend_q, pend_d;
  logic [hcbp_pkg::PendCntW-1:0] pend_cnt_q, pend_cnt_d;

  // Burst register: bytes still to send, the oldest in entry zero.
  logic [7:0]      bytes_q [MaxBytes];
  logic [7:0]      bytes_d [MaxBytes];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last_q, last_d;
  logic            burst_free;
  logic            out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = bytes_q[0];
  assign last_o      = last_q;
  assign out_fire    = out_valid_o && out_ready_i;

  // The burst register can take a new item once its last byte leaves.
  assign burst_free = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign s1_take    = s1_valid_q && burst_free;
  assign in_ready_o = !s1_valid_q || burst_free;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_take);

  // Encode: join the waiting bits with the code, left-align the result and
  // cut whole bytes from the top.
  logic [AccW-1:0] acc;
  logic [AccW-1:0] acc_al;
  logic [TotW-1:0] total;
  logic [TotW-1:0] nbytes;
  logic [2:0]      rem;
  logic [7:0]      flush_byte;

  always_comb begin
    acc    = (AccW'(pend_q) << tab_len) | AccW'(tab_code);
    total  = TotW'(pend_cnt_q) + TotW'(tab_len);
    acc_al = acc << (TotW'(AccW) - total);
    nbytes = total >> 3;
    rem    = total[2:0];
    flush_byte = 8'(8'(pend_q) << (4'(hcbp_pkg::ByteBits) - 4'(pend_cnt_q)));
  end

  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    for (int k = 0; k < MaxBytes; k++) begin
      bytes_d[k] = bytes_q[k];
    end

    // A sent byte moves the rest of the burst down by one entry.
    if (out_fire) begin
      cnt_d = cnt_q - CntW'(1);
      for (int k = 0; k < MaxBytes - 1; k++) begin
        bytes_d[k] = bytes_q[k + 1];
      end
    end

    if (s1_take) begin
      case (s1_action_q)
        hcbp_pkg::ActEncode: begin
          for (int k = 0; k < MaxBytes; k++) begin
            bytes_d[k] = acc_al[AccW-1-8*k -: 8];
          end
          cnt_d  = CntW'(nbytes);
          last_d = 1'b0;
          for (int i = 0; i < hcbp_pkg::PendW; i++) begin
            pend_d[i] = acc[i] && (i < int'(rem));
          end
          pend_cnt_d = rem;
        end
        hcbp_pkg::ActFlush: begin
          if (pend_cnt_q != '0) begin
            bytes_d[0] = flush_byte;
            cnt_d      = CntW'(1);
            last_d     = 1'b1;
          end
          pend_d     = '0;
          pend_cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_action_q <= hcbp_pkg::ActNone;
      pend_q      <= '0;
      pend_cnt_q  <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        s1_action_q <= hcbp_pkg::action_e'(action_i);
      end
      pend_q     <= pend_d;
      pend_cnt_q <= pend_cnt_d;
      cnt_q      <= cnt_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxBytes; k++) begin
      bytes_q[k] <= bytes_d[k];
    end
  end

  // The burst never holds more bytes than one item can make.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("burst count above its limit");

  // A byte marked last is the only byte of its burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (cnt_q == CntW'(1)))
    else $error("last byte shares its burst");

  // A flush leaves the accumulator empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && (s1_action_q == hcbp_pkg::ActFlush)) |=>
    ((pend_cnt_q == '0) && (pend_q == '0)))
    else $error("accumulator not empty after flush");

  // No new item moves on while bytes of an earlier one remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && (cnt_q > CntW'(1))) |-> 1'b0)
    else $error("burst overwritten before it was sent");

endmodule

// ----- test/tb_huffman_code_bit_packer.sv -----
// Self-checking testbench for the Huffman code bit packer: table loads, encodes and flushes.
module tb_huffman_code_bit_packer;

  // Lengths above this are clipped when a table entry is written.
  localparam int LenCap = (hcbp_pkg::MaxCodeLenDef < hcbp_pkg::CodeBitsW) ?
                          hcbp_pkg::MaxCodeLenDef : hcbp_pkg::CodeBitsW;
  localparam int RandItems = 230;
  // The long receiver hold-off starts once this many input beats are in.
  localparam int HoldAtItem = 80;
  localparam int HoldCycles = 300;
  localparam int DrainLimit = 4000;
  localparam int TimeoutCycles = 400000;
  localparam int MaxReports = 200;

  typedef struct packed {
    hcbp_pkg::action_e act;
    logic [7:0]        sym;
    logic [31:0]       bits;
    logic [5:0]        len;
  } code_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = hcbp_pkg::ActNone;
  logic [7:0]  symbol_i = '0;
  logic [31:0] code_bits_i = '0;
  logic [5:0]  code_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;

  huffman_code_bit_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Items waiting to be offered, and the bytes the packer still owes us.
  code_item_t   item_q [$];
  packed_byte_t packed_bytes_q [$];

  // Shadow of the packer: code table plus the bit accumulator.
  logic [31:0]  code_word_tab [256];
  logic [5:0]   code_len_tab [256];
  logic [6:0]   pend_bits = '0;
  logic [2:0]   pend_cnt = '0;

  // Symbols loaded so far on the stimulus side; only these are ever encoded,
  // since an entry that was never written has no defined content.
  bit           gen_loaded [256];
  logic [7:0]   gen_syms [$];

  int unsigned  n_errors = 0;
  int unsigned  n_load = 0, n_encode = 0, n_flush = 0, n_ignored = 0;
  int unsigned  n_bytes = 0, n_lasts = 0;
  int unsigned  items_taken = 0;

  int unsigned  tx_gap_left = 0, rx_stall_left = 0, hold_left = 0;
  bit           hold_done = 1'b0;
  bit           tx_steady = 1'b0, rx_steady = 1'b0;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("%0t: %s", $time, msg);
  endtask

  function automatic logic [63:0] low_mask(input int unsigned n);
    return (64'd1 << n) - 64'd1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Applies one accepted input beat to the shadow state and queues the
  // bytes it must produce.
  task automatic encode_and_pack(input code_item_t it);
    logic [63:0]  acc;
    logic [7:0]   tail;
    int unsigned  clen, total, nb;
    packed_byte_t pb;
    case (it.act)
      hcbp_pkg::ActLoad: begin
        // Overlong lengths saturate; code bits above the length are dropped.
        clen = (it.len > LenCap) ? LenCap : it.len;
        code_len_tab[it.sym] = 6'(clen);
        code_word_tab[it.sym] = 32'({32'd0, it.bits} & low_mask(clen));
        n_load++;
      end
      hcbp_pkg::ActEncode: begin
        n_encode++;
        clen = code_len_tab[it.sym];
        // An empty code appends nothing.
        if (clen != 0) begin
          acc = ({57'd0, pend_bits} << clen) | {32'd0, code_word_tab[it.sym]};
          total = pend_cnt + clen;
          nb = 0;
          while (total >= hcbp_pkg::ByteBits && nb < 4) begin
            total -= hcbp_pkg::ByteBits;
            pb.data = 8'(acc >> total);
            pb.last = 1'b0;
            packed_bytes_q.insert(packed_bytes_q.size(), pb);
            nb++;
          end
          pend_bits = 7'(acc & low_mask(total));
          pend_cnt = 3'(total);
        end
      end
      hcbp_pkg::ActFlush: begin
        n_flush++;
        // With nothing pending a flush produces no byte.
        if (pend_cnt != 0) begin
          tail = {1'b0, pend_bits};
          tail = tail << (hcbp_pkg::ByteBits - pend_cnt);
          pb.data = tail;
          pb.last = 1'b1;
          packed_bytes_q.insert(packed_bytes_q.size(), pb);
        end
        pend_bits = '0;
        pend_cnt = '0;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic queue_item(input hcbp_pkg::action_e act, input logic [7:0] sym,
                            input logic [31:0] bits, input logic [5:0] len);
    code_item_t it;
    it.act = act;
    it.sym = sym;
    it.bits = bits;
    it.len = len;
    item_q.insert(item_q.size(), it);
    if (act == hcbp_pkg::ActLoad && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      gen_syms.insert(gen_syms.size(), sym);
    end
  endtask

  // Phases with and without idling on each side.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 49) == 0) tx_steady <= !tx_steady;
    if ($urandom_range(0, 49) == 0) rx_steady <= !rx_steady;
  end

  // Sender: offers the queued items; the prediction is made from the payload
  // actually on the pins when the beat is taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    code_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= hcbp_pkg::ActNone;
      symbol_i <= '0;
      code_bits_i <= '0;
      code_length_i <= '0;
      tx_gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        encode_and_pack('{act: hcbp_pkg::action_e'(action_i), sym: symbol_i,
                          bits: code_bits_i, len: code_length_i});
        items_taken <= items_taken + 1;
      end
      if (tx_gap_left != 0) begin
        tx_gap_left <= tx_gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (item_q.size() != 0) begin
        nxt = item_q.pop_front();
        in_valid_i <= 1'b1;
        action_i <= nxt.act;
        symbol_i <= nxt.sym;
        code_bits_i <= nxt.bits;
        code_length_i <= nxt.len;
        tx_gap_left <= (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering, so that the
  // packer backs up and drops in_ready_o.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= HoldAtItem) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks every output beat against the oldest expected byte.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    packed_byte_t exp_b;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (packed_bytes_q.size() == 0) begin
          flag_error($sformatf("unexpected beat: expected none, got byte %02h last %0b",
                               out_byte_o, last_o));
        end else begin
          exp_b = packed_bytes_q.pop_front();
          n_bytes++;
          if (exp_b.last) n_lasts++;
          if (out_byte_o !== exp_b.data)
            flag_error($sformatf("out_byte mismatch: expected %02h, got %02h",
                                 exp_b.data, out_byte_o));
          if (last_o !== exp_b.last)
            flag_error($sformatf("last mismatch: expected %0b, got %0b",
                                 exp_b.last, last_o));
        end
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall_left <= pick_gap();
      end
    end
  end

  initial begin
    #(TimeoutCycles * 20);
    $display("%0t: timeout with %0d items and %0d bytes outstanding",
             $time, item_q.size(), packed_bytes_q.size());
    $display("FAIL huffman_code_bit_packer");
    $finish;
  end

  initial begin
    int unsigned n_rand, pick, lp, k;
    logic [5:0]  len;

    // Directed opening: reset state, length extremes, saturation, masking,
    // empty codes, the unused action and flushes with and without pending bits.
    queue_item(hcbp_pkg::ActFlush, 8'h00, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActNone, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    queue_item(hcbp_pkg::ActLoad, 8'h00, 32'hFFFF_FFFF, 6'd32);
    queue_item(hcbp_pkg::ActLoad, 8'hFF, 32'h0000_0000, 6'd1);
    queue_item(hcbp_pkg::ActLoad, 8'h5A, 32'hFFFF_FFFF, 6'd0);
    queue_item(hcbp_pkg::ActLoad, 8'hA5, 32'hDEAD_BEEF, 6'd63);
    queue_item(hcbp_pkg::ActLoad, 8'h3C, 32'hFFFF_FFF5, 6'd3);
    queue_item(hcbp_pkg::ActLoad, 8'hC3, 32'h0000_00AB, 6'd33);
    queue_item(hcbp_pkg::ActEncode, 8'h00, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'h5A, 32'hFFFF_FFFF, 6'h3F);
    queue_item(hcbp_pkg::ActEncode, 8'h3C, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'hA5, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'hFF, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActFlush, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    queue_item(hcbp_pkg::ActFlush, 8'h00, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'hC3, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'h3C, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActNone, 8'h00, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'h3C, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActLoad, 8'h81, 32'h0000_0055, 6'd7);
    queue_item(hcbp_pkg::ActEncode, 8'h81, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'h81, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActEncode, 8'h00, 32'h0, 6'd0);
    queue_item(hcbp_pkg::ActFlush, 8'h00, 32'h0, 6'd0);

    // Random part: mostly encodes of loaded symbols, with table rewrites,
    // flushes at random points and some beats of the unused action.
    n_rand = 0;
    while (n_rand < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < ((n_rand < 30) ? 40 : 10) || gen_syms.size() == 0) begin
        lp = $urandom_range(0, 99);
        if (lp < 4) len = 6'd0;
        else if (lp < 80) len = 6'($urandom_range(1, 12));
        else if (lp < 95) len = 6'($urandom_range(13, 32));
        else len = 6'($urandom_range(33, 63));
        queue_item(hcbp_pkg::ActLoad, 8'($urandom_range(0, 255)), $urandom, len);
        n_rand++;
      end else if (pick < 84) begin
        queue_item(hcbp_pkg::ActEncode, gen_syms[$urandom_range(0, gen_syms.size() - 1)],
                   $urandom, 6'($urandom_range(0, 63)));
        n_rand++;
      end else if (pick < 94) begin
        queue_item(hcbp_pkg::ActFlush, 8'($urandom_range(0, 255)), $urandom,
                   6'($urandom_range(0, 63)));
        n_rand++;
      end else begin
        queue_item(hcbp_pkg::ActNone, 8'($urandom_range(0, 255)), $urandom,
                   6'($urandom_range(0, 63)));
      end
    end
    queue_item(hcbp_pkg::ActFlush, 8'h00, 32'h0, 6'd0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || in_valid_i) @(posedge clk_i);
    for (k = 0; k < DrainLimit && packed_bytes_q.size() != 0; k++) @(posedge clk_i);
    // Keep watching after the queue drains to catch any stray byte after the last expected one.
    repeat (16) @(posedge clk_i);
    while (packed_bytes_q.size() != 0) begin
      flag_error($sformatf("missing beat: expected byte %02h last %0b, got none",
                           packed_bytes_q[0].data, packed_bytes_q[0].last));
      void'(packed_bytes_q.pop_front());
    end

    $display("Covered %0d table loads, %0d encodes, %0d flushes, %0d ignored beats.",
             n_load, n_encode, n_flush, n_ignored);
    $display("Checked %0d output bytes, %0d of them flush tails; %0d errors.",
             n_bytes, n_lasts, n_errors);
    if (n_errors == 0) begin
      $display("PASS huffman_code_bit_packer");
    end else begin
      $display("FAIL huffman_code_bit_packer");
    end
    $finish;
  end

endmodule
